// ===== hdl/cbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbn_pkg: shared types and constants of the cascaded biquad notch filter
// Widths of samples, signals, coefficients and the configuration port, and
// the record that one section hands on to the next.
// ----------------------------------------------------------------------------
package cbn_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int SIG_W              = 48;
  localparam int COEF_W             = 32;
  localparam int CFG_W              = 2 * COEF_W;
  localparam int NUM_REGS           = 8;
  localparam int CFG_ADDR_W         = $clog2(NUM_REGS);
  localparam int MAX_STAGES         = NUM_REGS / 2;
  localparam int DEF_STAGES         = 4;
  localparam int DEF_COEF_FRAC_BITS = 30;

  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [SIG_W-1:0] z;
  } link_t;

endpackage

// ===== hdl/cascaded_biquad_notch_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_biquad_notch_filter: cascaded biquad IIR filter, direct form II
// A chain of STAGES second-order sections with 16-bit saturated output.
// ----------------------------------------------------------------------------
// The input register takes a new sample once the last one has left it at a
// step. Each section closes its own recursion between steps (partial
// products, scaled products, feedback sum, feedforward sum into the next
// section), and all sections step together, so the chain holds up to STAGES
// samples at once. A sample waits for the next step and then moves on by
// one section at each step until it reaches the output register. The chain
// holds while a finished sample waits at the output. Coefficients are
// signed with COEF_FRAC_BITS fraction bits, a1 or b1 in the upper half of
// each 64-bit register and a2 or b2 in the lower half; write them only while
// the filter is empty.
// ----------------------------------------------------------------------------
module cascaded_biquad_notch_filter
  import cbn_pkg::*;
#(
  parameter int STAGES         = DEF_STAGES,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // sample_in
  input  logic                  s_axis_tlast,   // block_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,   // sample_out
  output logic                  m_axis_tlast,   // block_end_out
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [1:0] PHASE_LAST = 2'd3;
  localparam int         USED_REGS  = 2 * STAGES;

  logic [CFG_W-1:0]           regs [NUM_REGS];
  logic [1:0]                 ph;
  logic                       step;
  logic                       adv;
  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last;
  link_t                      link [STAGES+1];
  logic signed [SIG_W-1:0]    y_shift;
  logic signed [SAMPLE_W-1:0] y_sat;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (cfg_we && ({1'b0, cfg_addr} < (CFG_ADDR_W+1)'(USED_REGS))) begin
      regs[cfg_addr] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= '0;
    end else begin
      ph <= ph + 2'd1;
    end
  end

  assign step = (ph == PHASE_LAST);
  assign adv  = step && (!link[STAGES].valid || !m_axis_tvalid || m_axis_tready);

  // input holding register
  assign s_axis_tready = !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (adv) begin
        in_valid <= 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= $signed(s_axis_tdata);
      in_last   <= s_axis_tlast;
    end
  end

  always_comb begin
    link[0].valid = in_valid;
    link[0].last  = in_last;
    link[0].z     = {{(SIG_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample} <<< COEF_FRAC_BITS;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_cell
    cbn_cell #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .fb      (regs[2*s]),
      .ff      (regs[2*s+1]),
      .link_in (link[s]),
      .link_out(link[s+1])
    );
  end

  // back to a 16-bit sample
  always_comb begin
    y_shift = link[STAGES].z >>> COEF_FRAC_BITS;
    if (y_shift[SIG_W-1:SAMPLE_W-1] != {(SIG_W-SAMPLE_W+1){y_shift[SIG_W-1]}}) begin
      y_sat = y_shift[SIG_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = y_shift[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && link[STAGES].valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (adv && link[STAGES].valid) begin
      m_axis_tdata <= y_sat;
      m_axis_tlast <= link[STAGES].last;
    end
  end

endmodule

// ===== hdl/cbn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbn_cell: one second-order section, direct form II
// Holds its own delay pair and works on the sample in its input register
// in turn through partial products, scaled products, feedback sum, then
// the feedforward sum goes to the next section at the step.
// ----------------------------------------------------------------------------
module cbn_cell
  import cbn_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [CFG_W-1:0] fb,
  input  logic [CFG_W-1:0] ff,
  input  link_t            link_in,
  output link_t            link_out
);

  localparam int HALF_W = SIG_W / 2;
  localparam int PHI_W  = COEF_W + HALF_W;
  localparam int PLO_W  = COEF_W + HALF_W + 1;
  localparam int PROD_W = COEF_W + SIG_W;
  localparam int SUM_W  = SIG_W + 2;

  link_t                    cur;
  logic signed [SIG_W-1:0]  d1;
  logic signed [SIG_W-1:0]  d2;
  logic signed [COEF_W-1:0] coef [4];
  logic signed [SIG_W-1:0]  dsrc [4];
  logic signed [PHI_W-1:0]  pp_hi [4];
  logic signed [PLO_W-1:0]  pp_lo [4];
  logic signed [PROD_W-1:0] full [4];
  logic signed [PROD_W-1:0] shifted [4];
  logic signed [SIG_W-1:0]  m [4];
  logic signed [SIG_W-1:0]  m_next [4];
  logic signed [SUM_W-1:0]  wsum;
  logic signed [SUM_W-1:0]  ysum;
  logic signed [SIG_W-1:0]  w_reg;

  function automatic logic signed [SIG_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:SIG_W-1] != {(PROD_W-SIG_W+1){v[PROD_W-1]}}) begin
      return v[PROD_W-1] ? SIG_MIN : SIG_MAX;
    end
    return v[SIG_W-1:0];
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:SIG_W-1] != {(SUM_W-SIG_W+1){v[SUM_W-1]}}) begin
      return v[SUM_W-1] ? SIG_MIN : SIG_MAX;
    end
    return v[SIG_W-1:0];
  endfunction

  // a1, a2, b1, b2 against w1, w2, w1, w2
  always_comb begin
    coef[0] = fb[CFG_W-1:COEF_W];
    coef[1] = fb[COEF_W-1:0];
    coef[2] = ff[CFG_W-1:COEF_W];
    coef[3] = ff[COEF_W-1:0];
    dsrc[0] = d1;
    dsrc[1] = d2;
    dsrc[2] = d1;
    dsrc[3] = d2;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pp_hi[i] <= PHI_W'(coef[i]) * PHI_W'($signed(dsrc[i][SIG_W-1:HALF_W]));
      pp_lo[i] <= PLO_W'(coef[i]) * PLO_W'($signed({1'b0, dsrc[i][HALF_W-1:0]}));
    end
  end

  // floor scaling of the full product, then clamp to the signal range
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      full[i] = ({{(PROD_W-PHI_W){pp_hi[i][PHI_W-1]}}, pp_hi[i]} <<< HALF_W)
              + {{(PROD_W-PLO_W){pp_lo[i][PLO_W-1]}}, pp_lo[i]};
      shifted[i] = full[i] >>> COEF_FRAC_BITS;
      m_next[i]  = sat_prod(shifted[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m[i] <= m_next[i];
    end
  end

  always_comb begin
    wsum = {{2{cur.z[SIG_W-1]}}, cur.z}
         - {{2{m[0][SIG_W-1]}}, m[0]}
         - {{2{m[1][SIG_W-1]}}, m[1]};
    ysum = {{2{w_reg[SIG_W-1]}}, w_reg}
         + {{2{m[2][SIG_W-1]}}, m[2]}
         + {{2{m[3][SIG_W-1]}}, m[3]};
  end

  always_ff @(posedge clk) begin
    w_reg <= sat_sum(wsum);
  end

  always_comb begin
    link_out.valid = cur.valid;
    link_out.last  = cur.last;
    link_out.z     = sat_sum(ysum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
    end else if (adv) begin
      cur <= link_in;
      if (cur.valid) begin
        d2 <= d1;
        d1 <= w_reg;
      end
    end
  end

endmodule
